// File: rtl/gbn_pkg.sv
// Shared types and constants of the Go-Back-N sender.
package gbn_pkg;

    localparam int BYTES_MAX = 20;
    localparam int PAY_W     = 8 * BYTES_MAX;

    // Item kinds on the input channel
    localparam logic [1:0] KIND_MSG   = 2'd0;
    localparam logic [1:0] KIND_ACK   = 2'd1;
    localparam logic [1:0] KIND_TIMER = 2'd2;

    // Timer actions on the output channel
    localparam logic [1:0] TMR_NONE  = 2'd0;
    localparam logic [1:0] TMR_START = 2'd1;
    localparam logic [1:0] TMR_STOP  = 2'd2;

    // Configuration register indexes
    localparam int         CFG_IDX_W        = 1;
    localparam int         CFG_DATA_W       = 16;
    localparam int         WL_W             = 4;
    localparam logic [0:0] CFG_WINDOW_LIMIT = 1'b0;
    localparam logic [0:0] CFG_TIMEOUT      = 1'b1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [4:0]  length;
        logic [31:0] check_value;
        logic [63:0] payload_a;
        logic [63:0] payload_b;
        logic [31:0] payload_c;
    } t_in_item;

    typedef struct packed {
        logic        send_valid;
        logic [31:0] out_seq;
        logic [31:0] out_ack;
        logic [4:0]  out_length;
        logic [31:0] out_check;
        logic [63:0] out_payload_a;
        logic [63:0] out_payload_b;
        logic [31:0] out_payload_c;
        logic [1:0]  timer_action;
        logic [15:0] timer_value;
        logic        last;
    } t_out_item;

    // One buffered packet
    typedef struct packed {
        logic [4:0]       length;
        logic [31:0]      check;
        logic [PAY_W-1:0] payload;   // byte 0 in the lowest bits
    } t_entry;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_EVAL,
        ST_RD,
        ST_RS,
        ST_OUT
    } t_state;

endpackage

// File: rtl/go_back_n_sender.sv
// Go-Back-N ARQ sender: framing, checksum, retransmission buffer and resend sequencer.
//
// Takes one word at a time on the input channel and holds o_stall high until every result word
// it causes has been taken. A message or an ack word runs its checksum through one shared 32-bit
// adder, one payload byte per cycle, and its single result word shows on o_valid once the
// checksum is done (after ST_SUM and ST_EVAL); a bad or out-of-window ack gives no result and frees
// the block at that point, while a full-window message and kind 3 give no result and free
// it at once. A timer expiry with N packets outstanding gives N result words, each read from the
// packet buffer (a memory of MAX_WINDOW entries with registered read) and shown after ST_RD and
// ST_RS, from acceptance for the first and from the previous word being taken for the rest; with
// nothing outstanding it gives one timer-start word in the cycle after acceptance.
// The buffer needs no clearing pass after reset: only slots holding outstanding packets are
// ever used for a result. Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data;
// the user must write it only while the block is idle, which the block itself does not enforce.
module go_back_n_sender #(
    parameter int MAX_WINDOW    = 8,
    parameter int PAYLOAD_BYTES = 20
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gbn_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  logic                     i_valid,
    output logic                     o_stall,
    input  gbn_pkg::t_in_item        i_item,
    // output channel
    output logic                     o_valid,
    input  logic                     i_stall,
    output gbn_pkg::t_out_item       o_item
);
    import gbn_pkg::*;

    localparam int IDX_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int EFF_W  = (CNT_W > WL_W) ? CNT_W : WL_W;
    localparam int BCNT_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    // bytes at or beyond PAYLOAD_BYTES read as zero
    localparam logic [PAY_W-1:0] PAY_MASK = {PAY_W{1'b1}} >> (8 * (BYTES_MAX - PAYLOAD_BYTES));

    // configuration registers
    logic [WL_W-1:0]  r_window_limit;
    logic [15:0]      r_timeout;

    // protocol state
    logic [31:0]      r_next_seq, r_base_seq;
    logic [IDX_W-1:0] r_next_idx, r_base_idx;

    // sequencer
    t_state           r_state, n_state;
    t_in_item         r_in;
    logic [PAY_W-1:0] r_pay;
    logic [31:0]      r_acc;
    logic [BCNT_W-1:0] r_bcnt;
    logic [IDX_W-1:0] r_rd_idx;
    logic [31:0]      r_rs_seq;
    logic [CNT_W-1:0] r_rs_left;
    logic             r_rs_first;
    t_out_item        r_out, n_out;

    // packet buffer
    t_entry           r_mem [MAX_WINDOW];
    t_entry           r_rd_data;

    logic [31:0]      outstanding;
    logic [EFF_W-1:0] eff_win;
    logic             win_full;
    logic             in_acc, out_acc;
    logic [PAY_W-1:0] in_pay;
    logic [7:0]       cur_byte;
    logic [31:0]      nb, ack_dist;
    logic             ack_ok;
    logic [IDX_W:0]   base_sum;
    logic [IDX_W-1:0] base_adv;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    assign outstanding = r_next_seq - r_base_seq;

    // window limit clamped to 1..MAX_WINDOW
    always_comb begin
        eff_win = EFF_W'(r_window_limit);
        if (r_window_limit == '0) begin
            eff_win = EFF_W'(1);
        end
        if (eff_win > EFF_W'(MAX_WINDOW)) begin
            eff_win = EFF_W'(MAX_WINDOW);
        end
    end
    assign win_full = outstanding >= 32'(eff_win);

    assign in_pay   = {i_item.payload_c, i_item.payload_b, i_item.payload_a} & PAY_MASK;
    assign cur_byte = r_pay[r_bcnt*8 +: 8];

    // ack evaluation: new base must lie in base..next
    assign nb       = r_in.ack_num + 32'd1;
    assign ack_dist = nb - r_base_seq;
    assign ack_ok   = (r_acc == r_in.check_value) && (ack_dist <= outstanding);
    // ack_dist never exceeds MAX_WINDOW here, so one conditional subtract wraps the slot
    assign base_sum = {1'b0, r_base_idx} + ack_dist[IDX_W:0];
    assign base_adv = (base_sum >= (IDX_W+1)'(MAX_WINDOW))
                    ? IDX_W'(base_sum - (IDX_W+1)'(MAX_WINDOW))
                    : base_sum[IDX_W-1:0];

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        idx_inc = (idx == IDX_W'(MAX_WINDOW - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    case (i_item.kind)
                        KIND_MSG:   n_state = win_full ? ST_IDLE : ST_SUM;
                        KIND_ACK:   n_state = ST_SUM;
                        KIND_TIMER: n_state = (outstanding == '0) ? ST_OUT : ST_RD;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SUM: begin
                if (r_bcnt == BCNT_W'(PAYLOAD_BYTES - 1)) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (r_in.kind == KIND_MSG || ack_ok) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD:   n_state = ST_RS;
            ST_RS:   n_state = ST_OUT;
            ST_OUT: begin
                if (out_acc) begin
                    n_state = r_out.last ? ST_IDLE : ST_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_stall = (r_state != ST_IDLE);
        o_valid = (r_state == ST_OUT);
        o_item  = r_out;
    end

    // result word framing
    always_comb begin
        n_out = r_out;
        case (r_state)
            ST_IDLE: begin
                // timeout with nothing outstanding: bare timer restart
                n_out              = '0;
                n_out.timer_action = TMR_START;
                n_out.timer_value  = r_timeout;
                n_out.last         = 1'b1;
            end
            ST_EVAL: begin
                n_out      = '0;
                n_out.last = 1'b1;
                if (r_in.kind == KIND_MSG) begin
                    n_out.send_valid    = 1'b1;
                    n_out.out_seq       = r_next_seq;
                    n_out.out_ack       = r_next_seq;
                    n_out.out_length    = r_in.length;
                    n_out.out_check     = r_acc;
                    n_out.out_payload_a = r_pay[63:0];
                    n_out.out_payload_b = r_pay[127:64];
                    n_out.out_payload_c = r_pay[159:128];
                    if (outstanding == '0) begin
                        n_out.timer_action = TMR_START;
                        n_out.timer_value  = r_timeout;
                    end
                end else if (nb == r_next_seq) begin
                    n_out.timer_action = TMR_STOP;
                end else begin
                    n_out.timer_action = TMR_START;
                    n_out.timer_value  = r_timeout;
                end
            end
            ST_RS: begin
                n_out               = '0;
                n_out.send_valid    = 1'b1;
                n_out.out_seq       = r_rs_seq;
                n_out.out_ack       = r_rs_seq;
                n_out.out_length    = r_rd_data.length;
                n_out.out_check     = r_rd_data.check;
                n_out.out_payload_a = r_rd_data.payload[63:0];
                n_out.out_payload_b = r_rd_data.payload[127:64];
                n_out.out_payload_c = r_rd_data.payload[159:128];
                n_out.last          = (r_rs_left == CNT_W'(1));
                if (r_rs_first) begin
                    n_out.timer_action = TMR_START;
                    n_out.timer_value  = r_timeout;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_window_limit <= WL_W'(8);
            r_timeout      <= 16'd200;
            r_next_seq     <= 32'd1;
            r_base_seq     <= 32'd1;
            r_next_idx     <= IDX_W'(1 % MAX_WINDOW);
            r_base_idx     <= IDX_W'(1 % MAX_WINDOW);
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_LIMIT: r_window_limit <= i_cfg_data[WL_W-1:0];
                    CFG_TIMEOUT:      r_timeout      <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (r_state == ST_EVAL) begin
                if (r_in.kind == KIND_MSG) begin
                    r_next_seq <= r_next_seq + 32'd1;
                    r_next_idx <= idx_inc(r_next_idx);
                end else if (ack_ok) begin
                    r_base_seq <= nb;
                    r_base_idx <= base_adv;
                end
            end
        end
    end

    // datapath: shared checksum adder, resend walk
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        case (r_state)
            ST_IDLE: begin
                r_in   <= i_item;
                r_pay  <= in_pay;
                r_bcnt <= '0;
                if (i_item.kind == KIND_MSG) begin
                    r_acc <= r_next_seq + r_next_seq + 32'(i_item.length);
                end else begin
                    r_acc <= i_item.seq_num + i_item.ack_num + 32'(i_item.length);
                end
                r_rd_idx   <= r_base_idx;
                r_rs_seq   <= r_base_seq;
                r_rs_left  <= outstanding[CNT_W-1:0];
                r_rs_first <= 1'b1;
            end
            ST_SUM: begin
                r_acc  <= r_acc + {{24{cur_byte[7]}}, cur_byte};
                r_bcnt <= r_bcnt + BCNT_W'(1);
            end
            ST_OUT: begin
                if (out_acc) begin
                    r_rd_idx   <= idx_inc(r_rd_idx);
                    r_rs_seq   <= r_rs_seq + 32'd1;
                    r_rs_left  <= r_rs_left - CNT_W'(1);
                    r_rs_first <= 1'b0;
                end
            end
            default: ;
        endcase
    end

    // packet buffer: written on send, read every cycle at the resend slot
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EVAL && r_in.kind == KIND_MSG) begin
            r_mem[r_next_idx] <= '{length: r_in.length, check: r_acc, payload: r_pay};
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    // never more packets in flight than the buffer holds
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        outstanding <= 32'(MAX_WINDOW))
        else $error("outstanding count beyond buffer depth");

    // a result without a packet is always the only one of its word
    a_bare_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_item.send_valid |-> o_item.last)
        else $error("bare timer result not marked last");

    // each further resend needs a fresh buffer read before it is shown
    a_resend_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && !o_item.last |=> !o_valid ##1 !o_valid)
        else $error("resend shown without buffer read");

    // input is taken only while no result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !o_valid)
        else $error("input accepted while a result is pending");

endmodule
